/* src/uidmtf_pkg.sv */
// Shared definitions for the unique-identifier move-to-front stack.
// Holds operation and status codes, field widths and parameter defaults.
// Depends on nothing.
`default_nettype none

package uidmtf_pkg;

    // Default sizes of the stack and of the flag vector per entry.
    localparam int DEFAULT_STACK_DEPTH = 16;
    localparam int DEFAULT_FLAG_COUNT  = 8;

    // Fixed widths of the transfer fields.
    localparam int ID_W        = 32;
    localparam int STAMP_W     = 64;
    localparam int FLAG_IDX_W  = 3;
    localparam int OUT_FLAGS_W = 8;
    localparam int DEPTH_W     = 5;

    // Operation codes carried by the input tuser.
    typedef enum logic [2:0] {
        FUNC_PUSH  = 3'd0,
        FUNC_POP   = 3'd1,
        FUNC_FIND  = 3'd2,
        FUNC_MARK  = 3'd3,
        FUNC_CLEAR = 3'd4
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* src/unique_id_move_to_front_stack.sv */
// Throughput: one operation at a time; the next input transfer is taken once the result has
// gone to the output register. Push and find search from the top of the stack; a push hit
// moves the entries above the hit down one slot before the identifier is written on top. Pop
// reads the top entry, mark reads, sets and writes back every entry from the bottom up, and
// clear and other codes go straight to the result. The stack memory has one read port and one
// write port; a result held in the output register delays the next one until taken.
// Top level of the move-to-front stack; depends on uidmtf_pkg. Synchronous active-low reset
// empties the stack at once; entry contents are not cleared.
`default_nettype none

module unique_id_move_to_front_stack #(
    parameter int STACK_DEPTH = uidmtf_pkg::DEFAULT_STACK_DEPTH,
    parameter int FLAG_COUNT  = uidmtf_pkg::DEFAULT_FLAG_COUNT
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Input channel.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata, lowest bit up: id[31:0], stamp[95:32], flag_index[98:96], zero pad[103:99].
    input  wire logic [103:0] s_axis_tdata,
    // tuser: func[2:0].
    input  wire logic [2:0]   s_axis_tuser,
    // Output channel.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata, lowest bit up: status[1:0], found[2], out_id[34:3], out_stamp[98:35],
    // out_flags[106:99], depth_now[111:107].
    output logic [111:0]      m_axis_tdata
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int XW = CW + 1;

    typedef struct packed {
        logic [FLAG_COUNT-1:0]          marks;
        logic [uidmtf_pkg::STAMP_W-1:0] stamp;
        logic [uidmtf_pkg::ID_W-1:0]    ident;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_TOP_WR,
        S_POP_DATA,
        S_MARK,
        S_RESP
    } t_state;

    // Control and operand registers.
    t_state                              r_state, n_state;
    logic [CW-1:0]                       r_fill, n_fill;
    logic [AW-1:0]                       r_ptr, n_ptr;
    uidmtf_pkg::t_func                   r_func, n_func;
    logic [uidmtf_pkg::ID_W-1:0]         r_id, n_id;
    logic [uidmtf_pkg::STAMP_W-1:0]      r_stamp, n_stamp;
    logic [uidmtf_pkg::FLAG_IDX_W-1:0]   r_flag_idx, n_flag_idx;
    logic [FLAG_COUNT-1:0]               r_keep, n_keep;

    // Result fields gathered during the operation.
    uidmtf_pkg::t_status                 r_res_status, n_res_status;
    logic                                r_res_found, n_res_found;
    logic [uidmtf_pkg::ID_W-1:0]         r_res_id, n_res_id;
    logic [uidmtf_pkg::STAMP_W-1:0]      r_res_stamp, n_res_stamp;
    logic [uidmtf_pkg::OUT_FLAGS_W-1:0]  r_res_flags, n_res_flags;

    // Output register.
    logic                                r_out_valid, n_out_valid;
    logic [111:0]                        r_out_data, n_out_data;

    // Stack memory and its ports.
    t_entry                              r_mem [STACK_DEPTH];
    t_entry                              r_rd_data;
    logic                                mem_re;
    logic [AW-1:0]                       rd_addr;
    logic                                mem_we;
    logic [AW-1:0]                       wr_addr;
    t_entry                              wr_data;

    // Helper terms.
    logic                                in_xfer;
    logic                                stack_full;
    logic [FLAG_COUNT-1:0]               flag_bit;
    logic [XW-1:0]                       ptr_x;
    logic [XW-1:0]                       fill_x;

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign stack_full = (r_fill == CW'(STACK_DEPTH));
    assign flag_bit   = FLAG_COUNT'(1) << r_flag_idx;
    assign ptr_x      = XW'(r_ptr);
    assign fill_x     = XW'(r_fill);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Sequencer: search from the top, move entries down, write back, pop, mark or clear, and report.
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_ptr        = r_ptr;
        n_func       = r_func;
        n_id         = r_id;
        n_stamp      = r_stamp;
        n_flag_idx   = r_flag_idx;
        n_keep       = r_keep;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_id     = r_res_id;
        n_res_stamp  = r_res_stamp;
        n_res_flags  = r_res_flags;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        mem_re       = 1'b0;
        rd_addr      = r_ptr;
        mem_we       = 1'b0;
        wr_addr      = r_ptr;
        wr_data      = r_rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_func       = uidmtf_pkg::t_func'(s_axis_tuser);
                    n_id         = s_axis_tdata[31:0];
                    n_stamp      = s_axis_tdata[95:32];
                    n_flag_idx   = s_axis_tdata[98:96];
                    n_res_status = uidmtf_pkg::STATUS_OK;
                    n_res_found  = 1'b0;
                    n_res_id     = '0;
                    n_res_stamp  = '0;
                    n_res_flags  = '0;
                    n_state      = S_RESP;
                    unique case (uidmtf_pkg::t_func'(s_axis_tuser))
                        uidmtf_pkg::FUNC_PUSH, uidmtf_pkg::FUNC_FIND: begin
                            if (r_fill != '0) begin
                                mem_re  = 1'b1;
                                rd_addr = AW'(r_fill - CW'(1));
                                n_ptr   = AW'(r_fill - CW'(1));
                                n_state = S_SEARCH;
                            end else if (uidmtf_pkg::t_func'(s_axis_tuser)
                                         == uidmtf_pkg::FUNC_PUSH) begin
                                n_state = S_TOP_WR;
                            end
                        end
                        uidmtf_pkg::FUNC_POP: begin
                            if (r_fill == '0) begin
                                n_res_status = uidmtf_pkg::STATUS_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                rd_addr = AW'(r_fill - CW'(1));
                                n_fill  = r_fill - CW'(1);
                                n_state = S_POP_DATA;
                            end
                        end
                        uidmtf_pkg::FUNC_MARK: begin
                            if ((32'(s_axis_tdata[98:96]) < FLAG_COUNT) && (r_fill != '0)) begin
                                mem_re  = 1'b1;
                                rd_addr = '0;
                                n_ptr   = '0;
                                n_state = S_MARK;
                            end
                        end
                        uidmtf_pkg::FUNC_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // One entry compared per cycle, the next read issued alongside.
            S_SEARCH: begin
                if (r_rd_data.ident == r_id) begin
                    n_res_found = 1'b1;
                    if (r_func == uidmtf_pkg::FUNC_FIND) begin
                        n_state = S_RESP;
                    end else begin
                        n_keep = r_rd_data.marks;
                        if (ptr_x + XW'(1) == fill_x) begin
                            n_state = S_TOP_WR;
                        end else begin
                            mem_re  = 1'b1;
                            rd_addr = r_ptr + AW'(1);
                            n_state = S_SHIFT;
                        end
                    end
                end else if (r_ptr == '0) begin
                    if (r_func == uidmtf_pkg::FUNC_FIND) begin
                        n_state = S_RESP;
                    end else if (stack_full) begin
                        n_res_status = uidmtf_pkg::STATUS_FULL;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_TOP_WR;
                    end
                end else begin
                    mem_re  = 1'b1;
                    rd_addr = r_ptr - AW'(1);
                    n_ptr   = r_ptr - AW'(1);
                end
            end

            // Move the entry above down into the slot at the pointer.
            S_SHIFT: begin
                mem_we  = 1'b1;
                wr_addr = r_ptr;
                wr_data = r_rd_data;
                if (ptr_x + XW'(2) < fill_x) begin
                    mem_re  = 1'b1;
                    rd_addr = r_ptr + AW'(2);
                    n_ptr   = r_ptr + AW'(1);
                end else begin
                    n_state = S_TOP_WR;
                end
            end

            // Place the pushed identifier on top.
            S_TOP_WR: begin
                mem_we        = 1'b1;
                wr_data.ident = r_id;
                wr_data.stamp = r_stamp;
                if (r_res_found) begin
                    wr_addr       = AW'(r_fill - CW'(1));
                    wr_data.marks = r_keep;
                end else begin
                    wr_addr       = AW'(r_fill);
                    wr_data.marks = '0;
                    n_fill        = r_fill + CW'(1);
                end
                n_state = S_RESP;
            end

            S_POP_DATA: begin
                n_res_id    = r_rd_data.ident;
                n_res_stamp = r_rd_data.stamp;
                n_res_flags = uidmtf_pkg::OUT_FLAGS_W'(r_rd_data.marks);
                n_state     = S_RESP;
            end

            // Read, set the flag and write back, one entry per cycle.
            S_MARK: begin
                mem_we        = 1'b1;
                wr_addr       = r_ptr;
                wr_data       = r_rd_data;
                wr_data.marks = r_rd_data.marks | flag_bit;
                if (ptr_x + XW'(1) < fill_x) begin
                    mem_re  = 1'b1;
                    rd_addr = r_ptr + AW'(1);
                    n_ptr   = r_ptr + AW'(1);
                end else begin
                    n_state = S_RESP;
                end
            end

            // Hand the result to the output register once it is free.
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {uidmtf_pkg::DEPTH_W'(r_fill), r_res_flags, r_res_stamp,
                                   r_res_id, r_res_found, r_res_status};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, fill count, operand and result registers, and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_ptr        <= n_ptr;
        r_func       <= n_func;
        r_id         <= n_id;
        r_stamp      <= n_stamp;
        r_flag_idx   <= n_flag_idx;
        r_keep       <= n_keep;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_id     <= n_res_id;
        r_res_stamp  <= n_res_stamp;
        r_res_flags  <= n_res_flags;
        r_out_data   <= n_out_data;
    end

    // Stack memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the stack depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(STACK_DEPTH))
        else $error("fill count exceeds stack depth");

    // Writes land at or below the current fill level.
    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (XW'(wr_addr) <= fill_x))
        else $error("memory write above the fill level");

    // An accepted input transfer is followed by the input ready going low.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !s_axis_tready)
        else $error("input accepted while an operation is in progress");
`endif

endmodule

`default_nettype wire
